// ===== sv/yp2r_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yp2r_pkg
// Types and constants shared by the YUV pixel pair to RGB converter.
// ----------------------------------------------------------------------------
package yp2r_pkg;

  // One pixel pair in: two luma samples and the chroma bytes they share.
  typedef struct packed {
    logic [7:0] luma_even;
    logic [7:0] luma_odd;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
  } in_t;

  // Two RGB pixels out.
  typedef struct packed {
    logic [7:0] red_even;
    logic [7:0] green_even;
    logic [7:0] blue_even;
    logic [7:0] red_odd;
    logic [7:0] green_odd;
    logic [7:0] blue_odd;
  } out_t;

  // Stage enables handed to one scale-and-clamp unit.
  typedef struct packed {
    logic clip;
    logic mul;
  } div_en_t;

  localparam int unsigned STAGES = 8;   // register stages, input to output
  localparam int unsigned NUM_W  = 25;  // signed numerator width
  localparam int unsigned QN_W   = 22;  // clipped numerator width (< 2560000)
  localparam int unsigned PROD_W = 23;  // 8-bit sample times 15-bit weight
  localparam int unsigned PG_W   = 21;  // 8-bit channel times green weight

  // Conversion weights, scaled by 10000.
  localparam logic [14:0] K_RV = 15'd15938;
  localparam logic [14:0] K_BU = 15'd20238;
  localparam logic [14:0] K_Y  = 15'd11644;
  localparam logic [14:0] K_GY = 15'd19837;
  localparam logic [12:0] K_GR = 13'd5094;
  localparam logic [12:0] K_GB = 13'd1942;

  localparam logic signed [NUM_W-1:0] R_OFS = 25'sd2221300;
  localparam logic signed [NUM_W-1:0] B_OFS = 25'sd2771300;
  localparam logic signed [NUM_W-1:0] G_OFS = 25'sd311710;

  // Numerators at or above this give a quotient above 255.
  localparam logic signed [NUM_W-1:0] SAT_NUM = 25'sd2560000;

  // n / 10000 == (n * RECIP) >> RECIP_SHIFT, exact for 0 <= n < 2560000.
  localparam logic [20:0]  RECIP       = 21'd1717987;
  localparam int unsigned  RECIP_SHIFT = 34;
  localparam int unsigned  MUL_W       = QN_W + 21;

  localparam logic [7:0] CHAN_MAX = 8'd255;

endpackage

// ===== sv/yp2r_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yp2r_div
// Two-stage divide by 10000 with clamp to 0..255.
// ----------------------------------------------------------------------------
module yp2r_div (
  input  logic                                  clk,
  input  yp2r_pkg::div_en_t                     en,
  input  logic signed [yp2r_pkg::NUM_W-1:0]     num_i,
  output logic [7:0]                            chan_o
);

  logic [yp2r_pkg::QN_W-1:0]  n_r;
  logic                       neg_r;
  logic                       sat_r;
  logic [yp2r_pkg::MUL_W-1:0] prod;
  logic [7:0]                 q_r;
  logic                       negq_r;
  logic                       satq_r;

  // clip stage: sign and overflow flags, numerator trimmed to its useful range
  always_ff @(posedge clk) begin
    if (en.clip) begin
      n_r   <= num_i[yp2r_pkg::QN_W-1:0];
      neg_r <= num_i[yp2r_pkg::NUM_W-1];
      sat_r <= (num_i >= yp2r_pkg::SAT_NUM);
    end
  end

  assign prod = yp2r_pkg::MUL_W'(n_r) * yp2r_pkg::MUL_W'(yp2r_pkg::RECIP);

  // reciprocal multiply; quotient only meaningful when neither flag is set
  always_ff @(posedge clk) begin
    if (en.mul) begin
      q_r    <= prod[yp2r_pkg::RECIP_SHIFT +: 8];
      negq_r <= neg_r;
      satq_r <= sat_r;
    end
  end

  assign chan_o = negq_r ? 8'd0 : (satq_r ? yp2r_pkg::CHAN_MAX : q_r);

endmodule

// ===== sv/yuv_pair_to_rgb_core.sv =====
`timescale 1ns / 1ps
// An accepted input transfer passes through eight stage registers to reach
// out_valid, the first loaded by the accepting edge.
// Throughput: one pixel pair per cycle while out_stall is low; a stalled output
// holds only the stages that are full, so bubbles ahead of it are squeezed out.
// Reset: rst_n (synchronous, active low) clears every stage valid bit; the
// data registers are not reset.
// ----------------------------------------------------------------------------
// yuv_pair_to_rgb_core
// BT.601 style conversion of a 4:2:0 pixel pair (two luma, shared U/V) to two
// RGB pixels, integer weights scaled by 10000, each channel clamped to 0..255.
// ----------------------------------------------------------------------------
module yuv_pair_to_rgb_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  yp2r_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output yp2r_pkg::out_t  out_data
);

  localparam int unsigned NS = yp2r_pkg::STAGES;
  localparam int unsigned NW = yp2r_pkg::NUM_W;
  localparam int unsigned PW = yp2r_pkg::PROD_W;
  localparam int unsigned GW = yp2r_pkg::PG_W;

  // --------------------------------------------------------------------------
  // Flow control
  // Stage i loads when it is empty or when stage i+1 is loading too. The chain
  // ends at the output register, which moves on unless out_stall holds it.
  // --------------------------------------------------------------------------
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (en[i]) begin
        vld_nxt[i] = (i == 0) ? in_valid : vld_r[(i == 0) ? 0 : i - 1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NS-1];

  // --------------------------------------------------------------------------
  // Stage 0: weight products of chroma (shared) and of each luma sample
  // --------------------------------------------------------------------------
  logic [PW-1:0] pv_r;     // 15938 * V
  logic [PW-1:0] pu_r;     // 20238 * U
  logic [PW-1:0] ry_r [2]; // 11644 * Y, feeds red and blue
  logic [PW-1:0] gy_r [2]; // 19837 * Y, feeds green

  logic [7:0] luma [2];
  assign luma[0] = in_data.luma_even;
  assign luma[1] = in_data.luma_odd;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pv_r <= PW'(in_data.chroma_v) * PW'(yp2r_pkg::K_RV);
      pu_r <= PW'(in_data.chroma_u) * PW'(yp2r_pkg::K_BU);
      for (int p = 0; p < 2; p++) begin
        ry_r[p] <= PW'(luma[p]) * PW'(yp2r_pkg::K_Y);
        gy_r[p] <= PW'(luma[p]) * PW'(yp2r_pkg::K_GY);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: red and blue numerators, green base term (luma part less offset)
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] rn_r [2];
  logic signed [NW-1:0] bn_r [2];
  logic signed [NW-1:0] gb1_r [2];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int p = 0; p < 2; p++) begin
        rn_r[p]  <= signed'(NW'(pv_r)) + signed'(NW'(ry_r[p])) - yp2r_pkg::R_OFS;
        bn_r[p]  <= signed'(NW'(pu_r)) + signed'(NW'(ry_r[p])) - yp2r_pkg::B_OFS;
        gb1_r[p] <= signed'(NW'(gy_r[p])) - yp2r_pkg::G_OFS;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2-3: red and blue scaled down and clamped; green base rides along
  // --------------------------------------------------------------------------
  yp2r_pkg::div_en_t    en_rb;
  yp2r_pkg::div_en_t    en_g;
  logic [7:0]           red_s3   [2];
  logic [7:0]           blue_s3  [2];
  logic signed [NW-1:0] gb2_r    [2];
  logic signed [NW-1:0] gb3_r    [2];

  assign en_rb.clip = en[2];
  assign en_rb.mul  = en[3];
  assign en_g.clip  = en[5];
  assign en_g.mul   = en[6];

  // --------------------------------------------------------------------------
  // Stage 4: green's clamped red and blue terms
  // Stages 5-6: green scaled down and clamped; red and blue ride along
  // Stage 7: output register
  // --------------------------------------------------------------------------
  logic [7:0]           red_s4_r  [2];
  logic [7:0]           blue_s4_r [2];
  logic [GW-1:0]        pgr_r     [2];
  logic [GW-1:0]        pgb_r     [2];
  logic signed [NW-1:0] gb4_r     [2];
  logic signed [NW-1:0] gnum      [2];
  logic [7:0]           red_s5_r  [2];
  logic [7:0]           blue_s5_r [2];
  logic [7:0]           red_s6_r  [2];
  logic [7:0]           blue_s6_r [2];
  logic [7:0]           green_s6  [2];
  yp2r_pkg::out_t       out_r;

  for (genvar p = 0; p < 2; p++) begin : g_pix
    yp2r_div u_red (
      .clk    (clk),
      .en     (en_rb),
      .num_i  (rn_r[p]),
      .chan_o (red_s3[p])
    );

    yp2r_div u_blue (
      .clk    (clk),
      .en     (en_rb),
      .num_i  (bn_r[p]),
      .chan_o (blue_s3[p])
    );

    always_ff @(posedge clk) begin
      if (en[2]) begin
        gb2_r[p] <= gb1_r[p];
      end
      if (en[3]) begin
        gb3_r[p] <= gb2_r[p];
      end
      if (en[4]) begin
        red_s4_r[p]  <= red_s3[p];
        blue_s4_r[p] <= blue_s3[p];
        pgr_r[p]     <= GW'(red_s3[p]) * GW'(yp2r_pkg::K_GR);
        pgb_r[p]     <= GW'(blue_s3[p]) * GW'(yp2r_pkg::K_GB);
        gb4_r[p]     <= gb3_r[p];
      end
      if (en[5]) begin
        red_s5_r[p]  <= red_s4_r[p];
        blue_s5_r[p] <= blue_s4_r[p];
      end
      if (en[6]) begin
        red_s6_r[p]  <= red_s5_r[p];
        blue_s6_r[p] <= blue_s5_r[p];
      end
    end

    // green numerator: luma part less the clamped red and blue contributions
    assign gnum[p] = gb4_r[p] - signed'(NW'(pgr_r[p])) - signed'(NW'(pgb_r[p]));

    yp2r_div u_green (
      .clk    (clk),
      .en     (en_g),
      .num_i  (gnum[p]),
      .chan_o (green_s6[p])
    );
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_r.red_even   <= red_s6_r[0];
      out_r.green_even <= green_s6[0];
      out_r.blue_even  <= blue_s6_r[0];
      out_r.red_odd    <= red_s6_r[1];
      out_r.green_odd  <= green_s6[1];
      out_r.blue_odd   <= blue_s6_r[1];
    end
  end

  assign out_data = out_r;

endmodule

// ===== sv/yp2r_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yp2r_checker
// Port-level checks on the pixel pair converter, bound to the top level.
// ----------------------------------------------------------------------------
module yp2r_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input yp2r_pkg::out_t  out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // input back-pressure only when the pipeline is full behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled output transfer");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind yuv_pair_to_rgb_core yp2r_checker u_yp2r_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/yuv_pair_to_rgb_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_pair_to_rgb_core_tb
// Self-checking bench for the YUV pixel pair to RGB converter. A directed set
// of corner pairs is followed by random pairs. The sender and the receiver
// idle at random in two of three pressure phases. Every RGB transfer is
// checked field by field against a behavioural model of the conversion.
// ----------------------------------------------------------------------------
module yuv_pair_to_rgb_core_tb;

  // Conversion weights, scaled by 10000.
  localparam int SCALE  = 10000;
  localparam int W_RV   = 15938;
  localparam int W_BU   = 20238;
  localparam int W_Y    = 11644;
  localparam int W_GY   = 19837;
  localparam int W_GR   = 5094;
  localparam int W_GB   = 1942;
  localparam int OFS_R  = 2221300;
  localparam int OFS_B  = 2771300;
  localparam int OFS_G  = 311710;
  localparam int CH_TOP = 255;

  localparam int RAND_PER_PHASE = 362;
  localparam int QUIET_LIMIT    = 4000;  // cycles with no transfer on either side

  // --------------------------------------------------------------------------
  // Expected RGB pairs, oldest first, and the model that produces them.
  // --------------------------------------------------------------------------
  class rgb_pair_ledger;
    yp2r_pkg::out_t rgb_due[$];
    int   errors;
    int   pairs_in;
    int   pairs_checked;
    int   clamps_low;
    int   clamps_high;

    // Drop the scale, then saturate to a byte.
    function logic [7:0] clamp_scaled(int num);
      int q;
      q = num / SCALE;              // truncates toward zero
      if (q < 0) begin
        clamps_low++;
        return 8'd0;
      end
      if (q > CH_TOP) begin
        clamps_high++;
        return 8'(CH_TOP);
      end
      return 8'(q);
    endfunction

    // Green uses red and blue after clamping.
    function void convert_pixel(input int y, input int u, input int v,
                                output logic [7:0] r, output logic [7:0] g,
                                output logic [7:0] b);
      r = clamp_scaled(W_RV * v - OFS_R + W_Y * y);
      b = clamp_scaled(W_BU * u - OFS_B + W_Y * y);
      g = clamp_scaled(W_GY * y - OFS_G - W_GR * int'(r) - W_GB * int'(b));
    endfunction

    function void note_pair(yp2r_pkg::in_t d);
      yp2r_pkg::out_t e;
      convert_pixel(int'(d.luma_even), int'(d.chroma_u), int'(d.chroma_v),
                    e.red_even, e.green_even, e.blue_even);
      convert_pixel(int'(d.luma_odd), int'(d.chroma_u), int'(d.chroma_v),
                    e.red_odd, e.green_odd, e.blue_odd);
      rgb_due.push_back(e);
      pairs_in++;
    endfunction

    function void cmp_chan(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_rgb(yp2r_pkg::out_t got);
      yp2r_pkg::out_t e;
      if (rgb_due.size() == 0) begin
        $error("RGB transfer with nothing outstanding: %h", got);
        errors++;
        return;
      end
      e = rgb_due.pop_front();
      pairs_checked++;
      cmp_chan("red_even",   e.red_even,   got.red_even);
      cmp_chan("green_even", e.green_even, got.green_even);
      cmp_chan("blue_even",  e.blue_even,  got.blue_even);
      cmp_chan("red_odd",    e.red_odd,    got.red_odd);
      cmp_chan("green_odd",  e.green_odd,  got.green_odd);
      cmp_chan("blue_odd",   e.blue_odd,   got.blue_odd);
    endfunction

    function int pending();
      return rgb_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  yp2r_pkg::in_t  in_data   = '0;
  yp2r_pkg::out_t out_data;

  int in_idle_pct  = 0;   // chance per item that the sender holds off a cycle
  int out_idle_pct = 0;   // chance per cycle that the receiver stalls

  rgb_pair_ledger ledger = new;

  initial begin
    forever #10 clk = ~clk;
  end

  yuv_pair_to_rgb_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Bias towards the byte extremes so that every clamp path gets exercised.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic yp2r_pkg::in_t random_pair();
    yp2r_pkg::in_t d;
    d.luma_even = pick_byte();
    d.luma_odd  = pick_byte();
    d.chroma_u  = pick_byte();
    d.chroma_v  = pick_byte();
    return d;
  endfunction

  // One transfer. Idle cycles carry junk data with valid low; once valid is
  // raised the payload holds until the DUT takes it.
  task automatic send_pair(input yp2r_pkg::in_t d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= yp2r_pkg::in_t'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    ledger.note_pair(d);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pair(random_pair());
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, check on every accepted transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      ledger.check_rgb(out_data);
    end
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Watchdog: gives up when neither side has moved for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, ledger.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    yp2r_pkg::in_t corners[$];

    // Byte extremes, mid grey, and pairs that drive each channel past
    // either end of its range (dark pixel with strong chroma pushes green
    // negative; bright pixel with weak chroma pushes green over the top).
    corners = '{
      '{8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hff, 8'hff, 8'hff, 8'hff},
      '{8'h00, 8'hff, 8'h00, 8'hff},
      '{8'hff, 8'h00, 8'hff, 8'h00},
      '{8'h00, 8'h00, 8'hff, 8'hff},
      '{8'hff, 8'hff, 8'h00, 8'h00},
      '{8'h80, 8'h80, 8'h80, 8'h80},
      '{8'h10, 8'heb, 8'h80, 8'h80},
      '{8'h7f, 8'h80, 8'h7f, 8'h80},
      '{8'h55, 8'haa, 8'h55, 8'haa},
      '{8'haa, 8'h55, 8'haa, 8'h55},
      '{8'h01, 8'hfe, 8'h01, 8'hfe},
      '{8'h00, 8'h10, 8'hff, 8'h00},
      '{8'h00, 8'h10, 8'h00, 8'hff},
      '{8'hc0, 8'h40, 8'h10, 8'hf0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender mostly busy, receiver mostly stalled.
    in_idle_pct  = 21;
    out_idle_pct = 85;
    foreach (corners[i]) send_pair(corners[i]);
    send_random(RAND_PER_PHASE);

    // Phase two: the other way round.
    in_idle_pct  = 85;
    out_idle_pct = 21;
    send_random(RAND_PER_PHASE);

    // Phase three: back to back at full rate.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_random(RAND_PER_PHASE);
    in_valid <= 1'b0;

    // Drain, then give stray results a chance to show up.
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4 * yp2r_pkg::STAGES) @(posedge clk);

    $display("%0d pixel pairs sent over three pressure phases, %0d RGB pairs checked",
             ledger.pairs_in, ledger.pairs_checked);
    $display("channels clamped to zero %0d times, to full scale %0d times",
             ledger.clamps_low, ledger.clamps_high);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/yp2r_pkg.sv
sv/yp2r_div.sv
sv/yuv_pair_to_rgb_core.sv
sv/yp2r_checker.sv
tb/yuv_pair_to_rgb_core_tb.sv
